FILE: hdl/upcp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the parameter command parser.
// Used by the parser, the result register and the top level; it depends on nothing else.
package upcp_pkg;

	// Number of fraction digits that are taken into account.
	localparam int unsigned FRAC_DIGITS = 5;

	localparam logic [7:0] ZERO_CHAR      = 8'h30;
	localparam logic [7:0] DOT_CHAR       = 8'h2E;
	localparam logic [7:0] START_RESET    = 8'h50;
	localparam logic [7:0] SEP_RESET      = 8'h3D;
	localparam logic [15:0] INT_MAX_VAL   = 16'hFFFF;
	localparam logic [3:0] DIGIT_TEN      = 4'd10;

	// Configuration register indexes.
	localparam logic CFG_START_CHAR = 1'b0;
	localparam logic CFG_SEP_CHAR   = 1'b1;

	// Frame phases, one-hot.
	typedef enum logic [3:0] {
		PH_WAIT_START = 4'b0001,
		PH_TAKE_ID    = 4'b0010,
		PH_WAIT_SEP   = 4'b0100,
		PH_PAYLOAD    = 4'b1000
	} phase_t;

	// One result item.
	typedef struct packed {
		logic [7:0]  param_id;
		logic [31:0] param_value;
		logic        saturated;
		logic        bad_char;
	} result_t;

	// Rounded Q16 weight of a fraction digit, round(65536 / 10^(pos+1)).
	function automatic logic [12:0] frac_weight(input logic [2:0] pos);
		logic [12:0] w;
		unique case (pos)
			3'd0:    w = 13'd6554;
			3'd1:    w = 13'd655;
			3'd2:    w = 13'd66;
			3'd3:    w = 13'd7;
			3'd4:    w = 13'd1;
			default: w = 13'd0;
		endcase
		return w;
	endfunction

endpackage

FILE: hdl/upcp_in_stage.sv
`timescale 1ns / 1ps
// Input register of the parameter command parser: holds one received byte.
// Depends on no package items.
module upcp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// The stage stalls only while it holds an item that cannot move on.
	assign in_stall = valid_s1 && !advance;

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Byte of the stage; loaded only with an accepted item.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

FILE: hdl/upcp_parser.sv
`timescale 1ns / 1ps
// Frame state machine and Q16.16 accumulators of the parameter command parser.
// Depends on upcp_pkg for the phase type, result type, constants and weights.
module upcp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  logic [7:0]         byte_s1,
	input  logic               advance,
	input  logic [7:0]         start_char,
	input  logic [7:0]         separator_char,
	output logic               emit,
	output upcp_pkg::result_t  result
);

	upcp_pkg::phase_t phase_q, phase_d;
	logic [7:0]  held_id_q, held_id_d;
	logic [15:0] int_acc_q, int_acc_d;
	logic [16:0] frac_acc_q, frac_acc_d;
	logic        seen_dot_q, seen_dot_d;
	logic [2:0]  frac_cnt_q, frac_cnt_d;
	logic        sat_q, sat_d;
	logic        bad_q, bad_d;

	logic        is_sep;
	logic        is_digit;
	logic [3:0]  digit;
	logic [19:0] int_next;
	logic [16:0] frac_next;
	logic [32:0] value_sum;

	assign is_sep   = (byte_s1 == separator_char);
	assign is_digit = (byte_s1 >= upcp_pkg::ZERO_CHAR) &&
		(byte_s1 <= upcp_pkg::ZERO_CHAR + 8'd9);
	assign digit    = 4'(byte_s1 - upcp_pkg::ZERO_CHAR);

	// Integer step: acc * 10 + digit, as shift and add.
	assign int_next = {1'b0, int_acc_q, 3'b000} + {3'b000, int_acc_q, 1'b0} + 20'(digit);

	// Fraction step: digit times its rounded weight, wrapped to 17 bits.
	assign frac_next = frac_acc_q + 17'(digit) * 17'(upcp_pkg::frac_weight(frac_cnt_q));

	// A separator in the payload closes the frame.
	assign emit = valid_s1 && (phase_q == upcp_pkg::PH_PAYLOAD) && is_sep;

	// Result item built from the held frame state.
	assign value_sum = {1'b0, int_acc_q, 16'h0000} + {16'h0000, frac_acc_q};
	always_comb begin
		result.param_id    = held_id_q;
		result.param_value = (sat_q || value_sum[32]) ? 32'hFFFF_FFFF : value_sum[31:0];
		result.saturated   = sat_q;
		result.bad_char    = bad_q;
	end

	// Next state for the byte in the input register.
	always_comb begin
		phase_d    = phase_q;
		held_id_d  = held_id_q;
		int_acc_d  = int_acc_q;
		frac_acc_d = frac_acc_q;
		seen_dot_d = seen_dot_q;
		frac_cnt_d = frac_cnt_q;
		sat_d      = sat_q;
		bad_d      = bad_q;
		unique case (phase_q)
			upcp_pkg::PH_WAIT_START: begin
				if (byte_s1 == start_char) begin
					phase_d = upcp_pkg::PH_TAKE_ID;
				end
			end
			upcp_pkg::PH_TAKE_ID: begin
				held_id_d = byte_s1 - upcp_pkg::ZERO_CHAR;
				phase_d   = upcp_pkg::PH_WAIT_SEP;
			end
			upcp_pkg::PH_WAIT_SEP: begin
				if (is_sep) begin
					int_acc_d  = '0;
					frac_acc_d = '0;
					seen_dot_d = 1'b0;
					frac_cnt_d = '0;
					sat_d      = 1'b0;
					bad_d      = 1'b0;
					phase_d    = upcp_pkg::PH_PAYLOAD;
				end
			end
			upcp_pkg::PH_PAYLOAD: begin
				priority if (is_sep) begin
					phase_d = upcp_pkg::PH_WAIT_START;
				end else if (is_digit) begin
					if (!seen_dot_q) begin
						if (int_next > 20'(upcp_pkg::INT_MAX_VAL)) begin
							int_acc_d = upcp_pkg::INT_MAX_VAL;
							sat_d     = 1'b1;
						end else begin
							int_acc_d = int_next[15:0];
						end
					end else if (32'(frac_cnt_q) < upcp_pkg::FRAC_DIGITS) begin
						frac_acc_d = frac_next;
						frac_cnt_d = frac_cnt_q + 3'd1;
					end
				end else if (byte_s1 == upcp_pkg::DOT_CHAR && !seen_dot_q) begin
					seen_dot_d = 1'b1;
				end else begin
					bad_d = 1'b1;
				end
			end
			default: begin
				phase_d = upcp_pkg::PH_WAIT_START;
			end
		endcase
	end

	// Frame state registers, updated when the byte moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= upcp_pkg::PH_WAIT_START;
			held_id_q  <= '0;
			int_acc_q  <= '0;
			frac_acc_q <= '0;
			seen_dot_q <= 1'b0;
			frac_cnt_q <= '0;
			sat_q      <= 1'b0;
			bad_q      <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_d;
			held_id_q  <= held_id_d;
			int_acc_q  <= int_acc_d;
			frac_acc_q <= frac_acc_d;
			seen_dot_q <= seen_dot_d;
			frac_cnt_q <= frac_cnt_d;
			sat_q      <= sat_d;
			bad_q      <= bad_d;
		end
	end

	// A closed frame always returns the parser to waiting for a start byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && advance) |=> (phase_q == upcp_pkg::PH_WAIT_START))
		else $error("parser did not return to start wait after a frame");

	// Saturation pins the integer part at its maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> (int_acc_q == upcp_pkg::INT_MAX_VAL))
		else $error("saturation flag without clamped integer part");

	// Fraction digits are only counted after the dot and never beyond the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(frac_cnt_q != 3'd0) |-> (seen_dot_q && (32'(frac_cnt_q) <= upcp_pkg::FRAC_DIGITS)))
		else $error("fraction digit count out of range");

	// State holds while the input byte cannot move on.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(int_acc_q) && $stable(frac_acc_q))
		else $error("parser state changed without an advancing byte");

endmodule

FILE: hdl/upcp_out_stage.sv
`timescale 1ns / 1ps
// Result register of the parameter command parser: holds one result item.
// Depends on upcp_pkg for the result type.
module upcp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  upcp_pkg::result_t  result,
	output logic               ready,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         param_id,
	output logic [31:0]        param_value,
	output logic               saturated,
	output logic               bad_char
);

	logic out_valid_q;
	upcp_pkg::result_t res_q;

	// The register can take a new item when empty or when its item leaves now.
	assign ready = !out_valid_q || !out_stall;

	// Valid bit of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready) begin
			out_valid_q <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign param_id    = res_q.param_id;
	assign param_value = res_q.param_value;
	assign saturated   = res_q.saturated;
	assign bad_char    = res_q.bad_char;

endmodule

FILE: hdl/uart_param_command_parser.sv
`timescale 1ns / 1ps
// Top level of the parameter command parser: config registers and stage wiring.
// Depends on upcp_pkg, upcp_in_stage, upcp_parser and upcp_out_stage.
//
// Parses frames "start, id, separator, decimal number, separator" from a stream
// of received bytes and gives one result item per closed frame: the id byte
// minus 0x30, the number in unsigned Q16.16 (up to five fraction digits, clamped
// at all ones), and flags for integer overflow and bad characters. One byte is
// taken every clock cycle except while the input register stalls; a result passes
// from its closing separator through the input register and then the result
// register to the output. Bytes that close no frame pass even while a result
// waits at the output; only a closing separator waits for the result register
// to free up. The start and separator bytes are written through the
// configuration port (index 0 and 1), which is always ready and
// should be written while no frame is in flight.
module uart_param_command_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  param_id,
	output logic [31:0] param_value,
	output logic        saturated,
	output logic        bad_char,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] start_char_q;
	logic [7:0] sep_char_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       emit;
	logic       out_ready;
	upcp_pkg::result_t result;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= upcp_pkg::START_RESET;
			sep_char_q   <= upcp_pkg::SEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				upcp_pkg::CFG_START_CHAR: start_char_q <= cfg_data;
				upcp_pkg::CFG_SEP_CHAR:   sep_char_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// A byte moves on unless it closes a frame while the result register is full.
	assign advance = valid_s1 && (!emit || out_ready);

	upcp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	upcp_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.byte_s1        (byte_s1),
		.advance        (advance),
		.start_char     (start_char_q),
		.separator_char (sep_char_q),
		.emit           (emit),
		.result         (result)
	);

	upcp_out_stage u_out_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (emit && advance),
		.result      (result),
		.ready       (out_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.param_id    (param_id),
		.param_value (param_value),
		.saturated   (saturated),
		.bad_char    (bad_char)
	);

endmodule
